FILE: rtl/trba_pkg.sv
// ----------------------------------------------------------------------------
// trba_pkg : shared types and constants for the tile run bitmap allocator
// request/response structs, command and status codes, sequencer states
// ----------------------------------------------------------------------------
package trba_pkg;

  localparam int TILES_PER_HEAP    = 64;
  localparam int POS_W             = 6;
  localparam int COUNT_W           = 7;
  localparam int TILE_ID_W         = 10;
  localparam int HEAP_FIELD_W      = TILE_ID_W - POS_W;
  localparam int ADDRESSABLE_HEAPS = 1 << HEAP_FIELD_W;
  localparam int MAX_HEAPS_DEFAULT = 16;
  localparam int STATUS_W          = 2;
  // wide enough to compare heap numbers against the open count and the limit
  localparam int CMP_W             = HEAP_FIELD_W + 2;
  // wide enough for offset plus run length
  localparam int SUM_W             = COUNT_W + 1;

  typedef logic [TILES_PER_HEAP-1:0] bitmap_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic                 cmd;
    logic [COUNT_W-1:0]   tile_count;
    logic [TILE_ID_W-1:0] start_tile;
  } req_t;

  typedef struct packed {
    logic [TILE_ID_W-1:0] tile_id;
    logic [STATUS_W-1:0]  status;
    logic                 new_heap;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIT,
    S_PICK,
    S_OPEN,
    S_FINISH
  } trba_state_t;

  // bits 0..n-1 set, n in 1..64
  function automatic bitmap_t run_mask(logic [COUNT_W-1:0] n);
    if (n >= COUNT_W'(TILES_PER_HEAP)) begin
      return '1;
    end
    return (bitmap_t'(1) << n[POS_W-1:0]) - bitmap_t'(1);
  endfunction

endpackage

FILE: rtl/trba_ram.sv
// ----------------------------------------------------------------------------
// trba_ram : generic single-write, single-read RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module trba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tile_run_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// tile_run_bitmap_allocator_top : first-fit allocator of contiguous tile runs
// allocate walks the open heaps in order, each through read, fit and pick, and opens a new
//   heap or reports full when none fits; free reads, checks and clears the run; a bad
//   length, or on free a closed heap or a run past the heap end, goes straight to the response
// one request at a time: the next is taken once the response is raised, even while it
//   is stalled; each heap step reads one bitmap, finds the fit vector
// reset: no heaps open, bitmaps are written when their heap opens, no clear pass
// ----------------------------------------------------------------------------
module tile_run_bitmap_allocator_top
  import trba_pkg::*;
#(
  parameter int MAX_HEAPS = MAX_HEAPS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int HEAP_LIMIT = (MAX_HEAPS < ADDRESSABLE_HEAPS) ? MAX_HEAPS : ADDRESSABLE_HEAPS;
  localparam int HIDX_W     = (HEAP_LIMIT > 1) ? $clog2(HEAP_LIMIT) : 1;
  localparam int CNT_W      = $clog2(HEAP_LIMIT + 1);

  trba_state_t         state, state_next;
  logic [CNT_W-1:0]    heaps_open, heaps_open_next;
  logic                rsp_valid_next;
  rsp_t                rsp_next;

  logic                op, op_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic [POS_W-1:0]    offset, offset_next;
  bitmap_t             base, base_next;
  logic [HIDX_W-1:0]   heap, heap_next;
  bitmap_t             occ, occ_next;
  bitmap_t             fit, fit_next;
  rsp_t                result, result_next;

  logic                mem_we;
  logic [HIDX_W-1:0]   mem_waddr;
  bitmap_t             mem_wdata;
  bitmap_t             mem_rdata;

  bitmap_t             fit_vec;
  logic [POS_W-1:0]    pick_pos;
  logic                found;
  logic [POS_W-1:0]    shamt;
  bitmap_t             shifted;
  logic [HEAP_FIELD_W-1:0] req_heap;

  trba_ram #(
    .WIDTH (TILES_PER_HEAP),
    .DEPTH (HEAP_LIMIT)
  ) u_occ_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (heap),
    .rdata (mem_rdata)
  );

  // positions where a run of count free tiles starts and stays inside the heap
  always_comb begin
    for (int p = 0; p < TILES_PER_HEAP; p++) begin
      fit_vec[p] = (((mem_rdata >> p) & base) == '0) &&
                   ((SUM_W'(p) + SUM_W'(count)) <= SUM_W'(TILES_PER_HEAP));
    end
  end

  // lowest candidate position
  always_comb begin
    pick_pos = '0;
    for (int p = TILES_PER_HEAP - 1; p >= 0; p--) begin
      if (fit[p]) begin
        pick_pos = POS_W'(p);
      end
    end
  end

  assign found    = |fit;
  // shared run shifter: free offset or picked position
  assign shamt    = (op == CMD_FREE) ? offset : pick_pos;
  assign shifted  = base << shamt;
  assign req_heap = req.start_tile[TILE_ID_W-1:POS_W];

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    heaps_open_next = heaps_open;
    rsp_valid_next  = rsp_valid;
    rsp_next        = rsp;
    op_next         = op;
    count_next      = count;
    offset_next     = offset;
    base_next       = base;
    heap_next       = heap;
    occ_next        = occ;
    fit_next        = fit;
    result_next     = result;
    mem_we          = 1'b0;
    mem_waddr       = heap;
    mem_wdata       = occ | shifted;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next     = req.cmd;
          count_next  = req.tile_count;
          offset_next = req.start_tile[POS_W-1:0];
          base_next   = run_mask(req.tile_count);
          heap_next   = '0;
          result_next = '{tile_id: '0, status: ST_BAD, new_heap: 1'b0};
          if (req.tile_count == '0 || req.tile_count > COUNT_W'(TILES_PER_HEAP)) begin
            state_next = S_FINISH;
          end else if (req.cmd == CMD_ALLOC) begin
            state_next = (heaps_open == '0) ? S_OPEN : S_READ;
          end else if ((CMP_W'(req_heap) >= CMP_W'(heaps_open)) ||
                       (CMP_W'(req_heap) >= CMP_W'(HEAP_LIMIT)) ||
                       ((SUM_W'(req.start_tile[POS_W-1:0]) + SUM_W'(req.tile_count)) >
                        SUM_W'(TILES_PER_HEAP))) begin
            state_next = S_FINISH;
          end else begin
            heap_next  = req_heap[HIDX_W-1:0];
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        state_next = S_FIT;
      end

      S_FIT: begin
        if (op == CMD_ALLOC) begin
          fit_next   = fit_vec;
          occ_next   = mem_rdata;
          state_next = S_PICK;
        end else begin
          // free needs every tile of the run taken
          if ((mem_rdata & shifted) == shifted) begin
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata & ~shifted;
            result_next = '{tile_id: '0, status: ST_OK, new_heap: 1'b0};
          end else begin
            result_next = '{tile_id: '0, status: ST_BAD, new_heap: 1'b0};
          end
          state_next = S_FINISH;
        end
      end

      S_PICK: begin
        if (found) begin
          mem_we      = 1'b1;
          mem_wdata   = occ | shifted;
          result_next = '{tile_id: {HEAP_FIELD_W'(heap), pick_pos},
                          status: ST_OK, new_heap: 1'b0};
          state_next  = S_FINISH;
        end else if ((CNT_W'(heap) + CNT_W'(1)) < heaps_open) begin
          heap_next  = heap + HIDX_W'(1);
          state_next = S_READ;
        end else begin
          state_next = S_OPEN;
        end
      end

      S_OPEN: begin
        if (CMP_W'(heaps_open) >= CMP_W'(HEAP_LIMIT)) begin
          result_next = '{tile_id: '0, status: ST_FULL, new_heap: 1'b0};
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = heaps_open[HIDX_W-1:0];
          mem_wdata       = base;
          heaps_open_next = heaps_open + CNT_W'(1);
          result_next     = '{tile_id: {HEAP_FIELD_W'(heaps_open), POS_W'(0)},
                              status: ST_OK, new_heap: 1'b1};
        end
        state_next = S_FINISH;
      end

      S_FINISH: begin
        // wait for the output register to free up
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = result;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heaps_open <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      heaps_open <= heaps_open_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp    <= rsp_next;
    op     <= op_next;
    count  <= count_next;
    offset <= offset_next;
    base   <= base_next;
    heap   <= heap_next;
    occ    <= occ_next;
    fit    <= fit_next;
    result <= result_next;
  end

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(heaps_open) <= CMP_W'(HEAP_LIMIT))
    else $error("open heap count beyond limit");

  a_read_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (CMP_W'(heap) < CMP_W'(heaps_open)))
    else $error("bitmap read of a heap that is not open");

  a_new_heap_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.new_heap) |-> (rsp.status == ST_OK && rsp.tile_id[POS_W-1:0] == '0))
    else $error("new heap response not at tile 0 of the heap");

  a_open_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPEN && CMP_W'(heaps_open) < CMP_W'(HEAP_LIMIT)) |=>
      (heaps_open == $past(heaps_open) + CNT_W'(1)))
    else $error("open count not advanced on new heap");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("response raised outside finish");

endmodule
